>>> hw/rtl/udpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpq_pkg
// Shared types, constants and status codes of the UDP port demultiplexer.
// ----------------------------------------------------------------------------
package udpq_pkg;

    // Default sizes.
    localparam int NUM_PORTS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_PAYLOAD_DEF = 4096;

    // Operation codes.
    localparam logic [1:0] OP_BIND    = 2'd0;
    localparam logic [1:0] OP_UNBIND  = 2'd1;
    localparam logic [1:0] OP_DELIVER = 2'd2;
    localparam logic [1:0] OP_RECEIVE = 2'd3;

    // Status codes.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_PORT   = 4'd1;
    localparam logic [3:0] ST_BOUND      = 4'd2;
    localparam logic [3:0] ST_FULL_TABLE = 4'd3;
    localparam logic [3:0] ST_NOT_BOUND  = 4'd4;
    localparam logic [3:0] ST_NOT_OWNER  = 4'd5;
    localparam logic [3:0] ST_EMPTY      = 4'd6;
    localparam logic [3:0] ST_MALFORMED  = 4'd7;
    localparam logic [3:0] ST_NOT_UDP    = 4'd8;
    localparam logic [3:0] ST_QUEUE_FULL = 4'd9;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd10;

    // Header constants.
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [16:0] HDR_IP    = 17'd34;
    localparam logic [16:0] HDR_ALL   = 17'd42;
    localparam logic [15:0] HDR_UDP   = 16'd8;

    // Input item.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] port_num;
        logic [7:0]  requester;
        logic [12:0] frame_len;
        logic [15:0] eth_type;
        logic [7:0]  ip_proto;
        logic [15:0] udp_len;
        logic [31:0] src_addr;
        logic [15:0] src_port_in;
        logic [15:0] max_len;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] out_src_addr;
        logic [15:0] out_src_port;
        logic [12:0] out_length;
    } t_out;

    // Descriptor as stored.
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] sport;
        logic [12:0] plen;
    } t_desc;

endpackage
`default_nettype wire

>>> hw/rtl/udpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpq_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module udpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/udp_port_demux_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_port_demux_queue_unit
// Bound-port table with per-port descriptor queues in one shared RAM.
// ----------------------------------------------------------------------------
// Each item passes a match step and then an update step: in the match step
// the port table (flip-flops, searched in parallel) is matched and the
// descriptor RAM is read at the queue head; in the update step the status is
// formed, the queue pointers and table are updated and the RAM is written.
// The block accepts one item at a time; a new item is taken once the result
// register is free or is being emptied. No clearing pass is needed after
// reset.
module udp_port_demux_queue_unit #(
    parameter int NUM_PORTS   = udpq_pkg::NUM_PORTS_DEF,
    parameter int QUEUE_DEPTH = udpq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = udpq_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire udpq_pkg::t_in    i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output udpq_pkg::t_out        o_data
);
    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AD = NUM_PORTS * QUEUE_DEPTH;
    localparam int AW = (AD > 1) ? $clog2(AD) : 1;
    localparam int DW = $bits(udpq_pkg::t_desc);
    localparam logic [16:0] MAXP = 17'(MAX_PAYLOAD);

    // Port table and queue pointers.
    logic            r_vld   [NUM_PORTS];
    logic [15:0]     r_port  [NUM_PORTS];
    logic [7:0]      r_owner [NUM_PORTS];
    logic [QW-1:0]   r_head  [NUM_PORTS];
    logic [QW-1:0]   r_tail  [NUM_PORTS];
    logic [CW-1:0]   r_cnt   [NUM_PORTS];

    logic            r_busy;
    udpq_pkg::t_in   r_in;
    logic            r_hit;
    logic [PW-1:0]   r_idx;
    logic            r_free_ok;
    logic [PW-1:0]   r_free;

    // Search of the table for the incoming port and a free entry.
    logic            n_hit, n_free_ok;
    logic [PW-1:0]   n_idx, n_free;
    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        n_free_ok = 1'b0;
        n_free = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--) begin
            if (r_vld[i] && r_port[i] == i_data.port_num) begin
                n_hit = 1'b1;
                n_idx = PW'(i);
            end
            if (!r_vld[i]) begin
                n_free_ok = 1'b1;
                n_free = PW'(i);
            end
        end
    end

    // RAM address of an entry's slot.
    function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p,
                                                 input logic [QW-1:0] q);
        logic [31:0] a;
        a = 32'(p) * 32'(QUEUE_DEPTH) + 32'(q);
        return a[AW-1:0];
    endfunction

    logic accept;
    assign o_ready = !r_busy && (!o_valid || i_ready);
    assign accept  = i_valid && o_ready;

    // Descriptor RAM: read at head in the match step, write at tail in the update step.
    logic             we;
    logic [AW-1:0]    waddr;
    udpq_pkg::t_desc  wdesc, rdesc;
    logic [DW-1:0]    rbits;
    assign rdesc = udpq_pkg::t_desc'(rbits);

    udpq_ram #(.WIDTH(DW), .DEPTH(AD)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (DW'(wdesc)),
        .i_raddr (slot_addr(n_idx, r_head[n_idx])),
        .o_rdata (rbits)
    );

    // Update step: checks and update decisions.
    logic [3:0]      st;
    logic [16:0]     plen;
    logic [12:0]     clip;
    logic            do_bind, do_unbind, do_push, do_pop;
    always_comb begin
        plen = {1'b0, r_in.udp_len} - {1'b0, udpq_pkg::HDR_UDP};
        clip = (rdesc.plen > r_in.max_len[12:0] && r_in.max_len[15:13] == 3'd0)
            ? r_in.max_len[12:0] : rdesc.plen;
        do_bind = 1'b0;
        do_unbind = 1'b0;
        do_push = 1'b0;
        do_pop = 1'b0;
        st = udpq_pkg::ST_OK;
        unique case (r_in.op)
            udpq_pkg::OP_BIND: begin
                priority if (r_in.port_num == 16'd0) st = udpq_pkg::ST_BAD_PORT;
                else if (r_hit) st = udpq_pkg::ST_BOUND;
                else if (!r_free_ok) st = udpq_pkg::ST_FULL_TABLE;
                else do_bind = 1'b1;
            end
            udpq_pkg::OP_UNBIND: begin
                priority if (r_in.port_num == 16'd0) st = udpq_pkg::ST_BAD_PORT;
                else if (!r_hit) st = udpq_pkg::ST_NOT_BOUND;
                else if (r_owner[r_idx] != r_in.requester) st = udpq_pkg::ST_NOT_OWNER;
                else do_unbind = 1'b1;
            end
            udpq_pkg::OP_DELIVER: begin
                priority if (r_in.eth_type != udpq_pkg::TYPE_IPV4)
                    st = udpq_pkg::ST_NOT_UDP;
                else if ({4'd0, r_in.frame_len} < udpq_pkg::HDR_ALL)
                    st = udpq_pkg::ST_MALFORMED;
                else if (r_in.ip_proto != udpq_pkg::PROTO_UDP)
                    st = udpq_pkg::ST_NOT_UDP;
                else if (r_in.udp_len < udpq_pkg::HDR_UDP)
                    st = udpq_pkg::ST_MALFORMED;
                else if ({4'd0, r_in.frame_len} < udpq_pkg::HDR_ALL + plen)
                    st = udpq_pkg::ST_MALFORMED;
                else if (!r_hit) st = udpq_pkg::ST_NOT_BOUND;
                else if (32'(r_cnt[r_idx]) >= 32'(QUEUE_DEPTH))
                    st = udpq_pkg::ST_QUEUE_FULL;
                else if (plen > MAXP) st = udpq_pkg::ST_TOO_LARGE;
                else do_push = 1'b1;
            end
            default: begin
                priority if (!r_hit) st = udpq_pkg::ST_NOT_BOUND;
                else if (r_owner[r_idx] != r_in.requester) st = udpq_pkg::ST_NOT_OWNER;
                else if (r_cnt[r_idx] == '0) st = udpq_pkg::ST_EMPTY;
                else do_pop = 1'b1;
            end
        endcase
        we = r_busy && do_push;
        waddr = slot_addr(r_idx, r_tail[r_idx]);
        wdesc.addr = r_in.src_addr;
        wdesc.sport = r_in.src_port_in;
        wdesc.plen = plen[12:0];
    end

    // Wrap of a queue pointer.
    function automatic logic [QW-1:0] nxt(input logic [QW-1:0] p);
        return (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + QW'(1);
    endfunction

    // Control, table and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_valid <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_vld[i] <= 1'b0;
                r_port[i] <= '0;
                r_owner[i] <= '0;
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_in <= i_data;
                r_hit <= n_hit;
                r_idx <= n_idx;
                r_free_ok <= n_free_ok;
                r_free <= n_free;
            end
            if (r_busy) begin
                r_busy <= 1'b0;
                o_valid <= 1'b1;
                o_data.status <= st;
                o_data.out_src_addr <= do_pop ? rdesc.addr : '0;
                o_data.out_src_port <= do_pop ? rdesc.sport : '0;
                o_data.out_length <= do_pop ? clip : '0;
                if (do_bind) begin
                    r_vld[r_free] <= 1'b1;
                    r_port[r_free] <= r_in.port_num;
                    r_owner[r_free] <= r_in.requester;
                    r_head[r_free] <= '0;
                    r_tail[r_free] <= '0;
                    r_cnt[r_free] <= '0;
                end
                if (do_unbind) begin
                    r_vld[r_idx] <= 1'b0;
                    r_port[r_idx] <= '0;
                    r_owner[r_idx] <= '0;
                    r_head[r_idx] <= '0;
                    r_tail[r_idx] <= '0;
                    r_cnt[r_idx] <= '0;
                end
                if (do_push) begin
                    r_tail[r_idx] <= nxt(r_tail[r_idx]);
                    r_cnt[r_idx] <= r_cnt[r_idx] + CW'(1);
                end
                if (do_pop) begin
                    r_head[r_idx] <= nxt(r_head[r_idx]);
                    r_cnt[r_idx] <= r_cnt[r_idx] - CW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire
